/* design/jadm_pkg.sv */
// Shared types, constants and helper functions for the joystick arcade drive mixer.
package jadm_pkg;

  // Field widths
  localparam int STICK_BITS_DEF = 12;
  localparam int DUTY_BITS      = 16;
  localparam int DIR_BITS       = 2;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = DUTY_BITS;

  // Output tdata: left_duty, right_duty, left_dir, right_dir, zero padded to bytes
  localparam int OUT_FIELD_BITS = 2 * DUTY_BITS + 2 * DIR_BITS;
  localparam int OUT_TDATA_W    = ((OUT_FIELD_BITS + 7) / 8) * 8;

  // Quotient bits produced by the divider; mapped results never exceed a duty
  localparam int QUO_BITS = DUTY_BITS;

  // Turn term: span 0..TURN_SPAN, then scaled by TURN_NUM / TURN_DEN toward zero
  localparam int TURN_SPAN  = 1400;
  localparam int TURN_NUM   = 700;
  localparam int TURN_DEN   = 1000;
  localparam int TURN_GCD   = 100;
  localparam int TURN_MUL   = TURN_NUM / TURN_GCD;
  localparam int TURN_DIV   = TURN_DEN / TURN_GCD;
  localparam int RECIP_SH   = 16;
  localparam int TURN_RECIP = ((1 << RECIP_SH) + TURN_DIV - 1) / TURN_DIV;
  localparam int OMAG_BITS  = $clog2(TURN_SPAN + 1);
  localparam int OM7_BITS   = $clog2(TURN_SPAN * TURN_MUL + 1);
  localparam int OSC_BITS   = $clog2(TURN_SPAN * TURN_MUL / TURN_DIV + 1);
  localparam int RPROD_BITS = OM7_BITS + RECIP_SH + 1;

  // Signed width of the mixing sums
  localparam int MIX_BITS = DUTY_BITS + 2;

  // Direction codes
  localparam logic [DIR_BITS-1:0] DIR_STOP = 2'd0;
  localparam logic [DIR_BITS-1:0] DIR_FWD  = 2'd1;
  localparam logic [DIR_BITS-1:0] DIR_BACK = 2'd2;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FWD_THRESHOLD       = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FWD_FULL            = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_REV_THRESHOLD       = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TURN_LOW_THRESHOLD  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TURN_HIGH_THRESHOLD = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TURN_FULL           = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DUTY_MIN            = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_DUTY_MAX            = 3'd7;

  // Register reset values
  localparam int FWD_THRESHOLD_RST       = 2040;
  localparam int FWD_FULL_RST            = 4040;
  localparam int REV_THRESHOLD_RST       = 1980;
  localparam int TURN_LOW_THRESHOLD_RST  = 1880;
  localparam int TURN_HIGH_THRESHOLD_RST = 1930;
  localparam int TURN_FULL_RST           = 4040;
  localparam int DUTY_MIN_RST            = 2800;
  localparam int DUTY_MAX_RST            = 4200;

  // How a clamped map resolves: below range is impossible here (value > start)
  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_FULL,
    MODE_DIV
  } map_mode_t;

  // floor(v / TURN_DIV) by reciprocal multiply, exact for v below 2^14
  function automatic logic [OSC_BITS-1:0] turn_scale(input logic [OM7_BITS-1:0] v);
    logic [RPROD_BITS-1:0] prod;
    prod = RPROD_BITS'(v) * RPROD_BITS'(TURN_RECIP);
    return prod[RECIP_SH +: OSC_BITS];
  endfunction

endpackage

/* design/jadm_div.sv */
// Pipelined restoring divider: one quotient bit per register stage.
module jadm_div #(
  parameter int DEN_W = 12,
  parameter int Q_W   = 16
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DEN_W+Q_W-1:0] num,
  input  logic [DEN_W-1:0]     den,
  output logic [Q_W-1:0]       quo
);

  // Requires num < den * 2^Q_W, so the top DEN_W bits start below den
  logic [DEN_W-1:0] rem_r [Q_W-1];
  logic [Q_W-1:0]   low_r [Q_W-1];
  logic [DEN_W-1:0] den_r [Q_W-1];
  logic [Q_W-1:0]   q_r   [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [DEN_W-1:0] rem_i;
    logic [Q_W-1:0]   low_i;
    logic [DEN_W-1:0] den_i;
    logic [Q_W-1:0]   q_i;
    logic [DEN_W:0]   trial;
    logic             ge;

    // Stage inputs
    if (k == 0) begin : g_first
      assign rem_i = num[DEN_W+Q_W-1:Q_W];
      assign low_i = num[Q_W-1:0];
      assign den_i = den;
      assign q_i   = '0;
    end else begin : g_next
      assign rem_i = rem_r[k-1];
      assign low_i = low_r[k-1];
      assign den_i = den_r[k-1];
      assign q_i   = q_r[k-1];
    end

    // Shift in the next numerator bit and try a subtract
    assign trial = {rem_i, low_i[Q_W-1]};
    assign ge    = (trial >= {1'b0, den_i});

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k] <= {q_i[Q_W-2:0], ge};
      end
    end

    if (k < Q_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? DEN_W'(trial - {1'b0, den_i}) : DEN_W'(trial);
          low_r[k] <= {low_i[Q_W-2:0], 1'b0};
          den_r[k] <= den_i;
        end
      end
    end
  end

  assign quo = q_r[Q_W-1];

endmodule

/* design/joystick_arcade_drive_mixer.sv */
// Arcade drive mixer: joystick sample in, duty and direction per motor out.
//
// Takes one joystick sample per transaction and returns one motor command per
// transaction, in order. The block accepts a sample every clock cycle while
// s_axis_tready is high, that is unless the skid entry is full. The depth is
// set by the two 16-stage restoring dividers (one for the base
// speed map, one for the turn map) plus setup, mixing and output stages. A
// two-entry output register and skid stage let a new sample in while a result
// waits; s_axis_tready drops only once both hold results. Registers are
// written through cfg_we/cfg_index/cfg_data and must only change while no
// transaction is in flight.
module joystick_arcade_drive_mixer
  import jadm_pkg::*;
#(
  parameter int STICK_BITS = STICK_BITS_DEF,
  localparam int IN_TDATA_W = ((2 * STICK_BITS + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  // Configuration writes
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  // Joystick samples
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [IN_TDATA_W-1:0]     s_axis_tdata,  // x_pos, y_pos, zero pad
  // Motor commands
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [OUT_TDATA_W-1:0]    m_axis_tdata   // left_duty, right_duty,
                                                   // left_dir, right_dir, zero pad
);

  localparam int SB = STICK_BITS;

  typedef struct packed {
    logic      fwd;
    map_mode_t base_mode;
    map_mode_t om_mode;
    logic      om_neg;
  } side_t;

  // Configuration registers
  logic [SB-1:0]        fwd_threshold;
  logic [SB-1:0]        fwd_full;
  logic [SB-1:0]        rev_threshold;
  logic [SB-1:0]        turn_low_threshold;
  logic [SB-1:0]        turn_high_threshold;
  logic [SB-1:0]        turn_full;
  logic [DUTY_BITS-1:0] duty_min;
  logic [DUTY_BITS-1:0] duty_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_threshold       <= SB'(FWD_THRESHOLD_RST);
      fwd_full            <= SB'(FWD_FULL_RST);
      rev_threshold       <= SB'(REV_THRESHOLD_RST);
      turn_low_threshold  <= SB'(TURN_LOW_THRESHOLD_RST);
      turn_high_threshold <= SB'(TURN_HIGH_THRESHOLD_RST);
      turn_full           <= SB'(TURN_FULL_RST);
      duty_min            <= DUTY_BITS'(DUTY_MIN_RST);
      duty_max            <= DUTY_BITS'(DUTY_MAX_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FWD_THRESHOLD:       fwd_threshold       <= cfg_data[SB-1:0];
        CFG_FWD_FULL:            fwd_full            <= cfg_data[SB-1:0];
        CFG_REV_THRESHOLD:       rev_threshold       <= cfg_data[SB-1:0];
        CFG_TURN_LOW_THRESHOLD:  turn_low_threshold  <= cfg_data[SB-1:0];
        CFG_TURN_HIGH_THRESHOLD: turn_high_threshold <= cfg_data[SB-1:0];
        CFG_TURN_FULL:           turn_full           <= cfg_data[SB-1:0];
        CFG_DUTY_MIN:            duty_min            <= cfg_data;
        CFG_DUTY_MAX:            duty_max            <= cfg_data;
        default: ;
      endcase
    end
  end

  // Duty span magnitude and direction (static while transactions run)
  logic                 duty_neg;
  logic [DUTY_BITS-1:0] duty_span;
  assign duty_neg  = (duty_max < duty_min);
  assign duty_span = duty_neg ? (duty_min - duty_max) : (duty_max - duty_min);

  // Pipeline advance: blocked only while the skid entry is full
  logic adv;
  logic skid_valid;
  assign adv           = !skid_valid;
  assign s_axis_tready = adv;

  // Valid bits
  logic           v1, v2, v3, v4, v5, v6, v7;
  logic [QUO_BITS-1:0] vd;

  // Stage 1: captured sample
  logic [SB-1:0] x1, y1;

  // Stage 2: map setup
  side_t         side2, side2_next;
  logic [SB-1:0] bdiff2, bden2, odiff2, oden2;
  logic [SB-1:0] bdiff2_next, bden2_next, odiff2_next, oden2_next;

  // Stage 3: numerator products
  side_t                 side3;
  logic [SB+QUO_BITS-1:0] bprod3, oprod3;
  logic [SB-1:0]          bden3, oden3;

  // Divider sideband shift line
  side_t sd [QUO_BITS];

  // Stage 4..7
  side_t                 side4, side5, side6;
  logic [DUTY_BITS-1:0]  base4, base5;
  logic [OM7_BITS-1:0]   om7_4;
  logic [OSC_BITS-1:0]   osc5, osc6;
  logic [DUTY_BITS-1:0]  left6, right6;
  logic                  base_zero6;
  logic [DUTY_BITS-1:0]  left7, right7;
  logic [DIR_BITS-1:0]   ldir7, rdir7;

  // Valid shift with reset
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vd <= '0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (adv) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
      vd <= {vd[QUO_BITS-2:0], v3};
      v4 <= vd[QUO_BITS-1];
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  // Stage 2 logic: pick band, map operands, saturation
  always_comb begin
    side2_next  = '{fwd: 1'b0, base_mode: MODE_ZERO, om_mode: MODE_ZERO, om_neg: 1'b0};
    bdiff2_next = '0;
    bden2_next  = '0;
    odiff2_next = '0;
    oden2_next  = '0;
    // Base speed
    if (x1 > fwd_threshold) begin
      side2_next.fwd       = 1'b1;
      side2_next.base_mode = (x1 >= fwd_full) ? MODE_FULL : MODE_DIV;
      bdiff2_next          = x1 - fwd_threshold;
      bden2_next           = fwd_full - fwd_threshold;
    end else if (x1 < rev_threshold) begin
      side2_next.base_mode = (x1 == '0) ? MODE_FULL : MODE_DIV;
      bdiff2_next          = rev_threshold - x1;
      bden2_next           = rev_threshold;
    end
    // Turn term; the right-turn band is tested first
    if (y1 < turn_low_threshold) begin
      side2_next.om_mode = (y1 == '0) ? MODE_FULL : MODE_DIV;
      odiff2_next        = turn_low_threshold - y1;
      oden2_next         = turn_low_threshold;
    end else if (y1 > turn_high_threshold) begin
      side2_next.om_neg  = 1'b1;
      side2_next.om_mode = (y1 >= turn_full) ? MODE_FULL : MODE_DIV;
      odiff2_next        = y1 - turn_high_threshold;
      oden2_next         = turn_full - turn_high_threshold;
    end
  end

  // Stage 4 logic: map results, turn times the scale numerator
  logic [QUO_BITS-1:0]  bquo, oquo;
  logic [DUTY_BITS-1:0] base4_next;
  logic [OMAG_BITS-1:0] omag4;

  always_comb begin
    case (sd[QUO_BITS-1].base_mode)
      MODE_FULL: base4_next = duty_max;
      MODE_DIV:  base4_next = duty_neg ? (duty_min - bquo) : (duty_min + bquo);
      default:   base4_next = '0;
    endcase
    case (sd[QUO_BITS-1].om_mode)
      MODE_FULL: omag4 = OMAG_BITS'(TURN_SPAN);
      MODE_DIV:  omag4 = oquo[OMAG_BITS-1:0];
      default:   omag4 = '0;
    endcase
  end

  // Stage 6 logic: mix and clamp to [0, duty_max]
  logic signed [MIX_BITS-1:0] base_s, om_s5, lsum, rsum;
  logic [DUTY_BITS-1:0]       left6_next, right6_next;

  always_comb begin
    base_s = $signed({2'b00, base5});
    om_s5  = $signed(MIX_BITS'(osc5));
    if (side5.om_neg) begin
      om_s5 = -om_s5;
    end
    lsum = base_s + om_s5;
    rsum = base_s - om_s5;
    if (lsum < 0) begin
      left6_next = '0;
    end else if (lsum > $signed({2'b00, duty_max})) begin
      left6_next = duty_max;
    end else begin
      left6_next = lsum[DUTY_BITS-1:0];
    end
    if (rsum < 0) begin
      right6_next = '0;
    end else if (rsum > $signed({2'b00, duty_max})) begin
      right6_next = duty_max;
    end else begin
      right6_next = rsum[DUTY_BITS-1:0];
    end
  end

  // Stage 7 logic: spin in place, idle, drive
  logic signed [MIX_BITS-1:0] om_s6, min_s, lspin, rspin;
  logic [DUTY_BITS-1:0]       left7_next, right7_next;
  logic [DIR_BITS-1:0]        ldir7_next, rdir7_next;

  always_comb begin
    om_s6 = $signed(MIX_BITS'(osc6));
    if (side6.om_neg) begin
      om_s6 = -om_s6;
    end
    min_s       = $signed({2'b00, duty_min});
    lspin       = min_s + om_s6;
    rspin       = min_s - om_s6;
    left7_next  = left6;
    right7_next = right6;
    ldir7_next  = side6.fwd ? DIR_FWD : DIR_BACK;
    rdir7_next  = side6.fwd ? DIR_FWD : DIR_BACK;
    if (base_zero6) begin
      if (osc6 == '0) begin
        // Deadband or idle
        left7_next  = '0;
        right7_next = '0;
        ldir7_next  = DIR_STOP;
        rdir7_next  = DIR_STOP;
      end else begin
        // Bump small duties to the minimum spin duty, saturating
        if (left6 != '0 && left6 < duty_min) begin
          if (lspin < 0) begin
            left7_next = '0;
          end else if (lspin[MIX_BITS-2:DUTY_BITS] != '0) begin
            left7_next = '1;
          end else begin
            left7_next = lspin[DUTY_BITS-1:0];
          end
        end
        if (right6 != '0 && right6 < duty_min) begin
          if (rspin < 0) begin
            right7_next = '0;
          end else if (rspin[MIX_BITS-2:DUTY_BITS] != '0) begin
            right7_next = '1;
          end else begin
            right7_next = rspin[DUTY_BITS-1:0];
          end
        end
        ldir7_next = side6.om_neg ? DIR_BACK : DIR_FWD;
        rdir7_next = side6.om_neg ? DIR_FWD : DIR_BACK;
      end
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      x1     <= s_axis_tdata[SB-1:0];
      y1     <= s_axis_tdata[2*SB-1:SB];
      side2  <= side2_next;
      bdiff2 <= bdiff2_next;
      bden2  <= bden2_next;
      odiff2 <= odiff2_next;
      oden2  <= oden2_next;
      side3  <= side2;
      bprod3 <= bdiff2 * duty_span;
      oprod3 <= odiff2 * QUO_BITS'(TURN_SPAN);
      bden3  <= bden2;
      oden3  <= oden2;
      sd[0]  <= side3;
      for (int k = 1; k < QUO_BITS; k++) begin
        sd[k] <= sd[k-1];
      end
      side4      <= sd[QUO_BITS-1];
      base4      <= base4_next;
      om7_4      <= OM7_BITS'(omag4) * OM7_BITS'(TURN_MUL);
      side5      <= side4;
      base5      <= base4;
      osc5       <= turn_scale(om7_4);
      side6      <= side5;
      osc6       <= osc5;
      left6      <= left6_next;
      right6     <= right6_next;
      base_zero6 <= (base5 == '0);
      left7      <= left7_next;
      right7     <= right7_next;
      ldir7      <= ldir7_next;
      rdir7      <= rdir7_next;
    end
  end

  // Dividers for the base map and the turn map
  jadm_div #(.DEN_W(SB), .Q_W(QUO_BITS)) u_base_div (
    .clk (clk),
    .en  (adv),
    .num (bprod3),
    .den (bden3),
    .quo (bquo)
  );

  jadm_div #(.DEN_W(SB), .Q_W(QUO_BITS)) u_turn_div (
    .clk (clk),
    .en  (adv),
    .num (oprod3),
    .den (oden3),
    .quo (oquo)
  );

  // Output register with skid entry
  logic [OUT_TDATA_W-1:0] last_data, skid_data;
  assign last_data = OUT_TDATA_W'({rdir7, ldir7, right7, left7});

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (skid_valid) begin
      if (m_axis_tready) begin
        skid_valid <= 1'b0;
      end
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= v7;
    end else if (v7) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_axis_tready) begin
        m_axis_tdata <= skid_data;
      end
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tdata <= last_data;
    end else begin
      skid_data <= last_data;
    end
  end

endmodule

/* design/jadm_checker.sv */
// Port-level assertions for the joystick arcade drive mixer, bound to the top level.
module jadm_checker
  import jadm_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [OUT_TDATA_W-1:0]    m_axis_tdata   // left_duty, right_duty,
                                                  // left_dir, right_dir, zero pad
);

  logic [DUTY_BITS-1:0] left_duty, right_duty;
  logic [DIR_BITS-1:0]  left_dir, right_dir;
  logic                 stop_any;

  assign left_duty  = m_axis_tdata[DUTY_BITS-1:0];
  assign right_duty = m_axis_tdata[2*DUTY_BITS-1:DUTY_BITS];
  assign left_dir   = m_axis_tdata[2*DUTY_BITS +: DIR_BITS];
  assign right_dir  = m_axis_tdata[2*DUTY_BITS+DIR_BITS +: DIR_BITS];
  assign stop_any   = (left_dir == DIR_STOP) || (right_dir == DIR_STOP);

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // Stopping is all or nothing: both motors stop with zero duty
  a_stop_pair: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && stop_any |->
      left_dir == DIR_STOP && right_dir == DIR_STOP &&
      left_duty == '0 && right_duty == '0)
    else $error("one motor stopped without the other");

  // Differing directions only as an opposite spin pair
  a_spin_pair: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && left_dir != right_dir |->
      (left_dir == DIR_FWD && right_dir == DIR_BACK) ||
      (left_dir == DIR_BACK && right_dir == DIR_FWD))
    else $error("mismatched motor directions");

  // Input back-pressure only while a result is waiting downstream
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no pending result");

  // Nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result offered after reset");

endmodule

bind joystick_arcade_drive_mixer jadm_checker u_jadm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
